/* sv/pvfd_pkg.sv */
// Package for the filtered-derivative velocity PID: widths, register indexes,
// microcode word layout and the control program.
// No dependencies; used by pvfd_mulq and pid_velocity_filtered_derivative.
package pvfd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumSteps = 19;
  localparam int unsigned PcW      = $clog2(NumSteps);
  localparam logic [PcW-1:0] LastStep = PcW'(NumSteps - 1);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_PI = 3'd0,
    REG_COEF_P  = 3'd1,
    REG_COEF_D  = 3'd2,
    REG_FILT_A  = 3'd3,
    REG_FILT_B  = 3'd4,
    REG_OUT_MIN = 3'd5,
    REG_OUT_MAX = 3'd6
  } cfg_reg_e;

  // coefficient feeding the multiplier
  typedef enum logic [2:0] {
    C_PI,
    C_P,
    C_D,
    C_FA,
    C_FB
  } coef_sel_e;

  // value feeding the multiplier
  typedef enum logic [1:0] {
    O_E0,
    O_E1,
    O_X,
    O_FD1
  } opnd_sel_e;

  // accumulate / move operations of the datapath
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_DD,
    ALU_ACC_ADD,
    ALU_ACC_SUB,
    ALU_SUMD,
    ALU_MOVT,
    ALU_FD,
    ALU_ACC_FD,
    ALU_CLAMP,
    ALU_EMIT
  } alu_op_e;

  // multiplier unit controls
  typedef struct packed {
    logic ld;   // load sign/magnitudes of both operands
    logic mlo;  // low partial product
    logic mhi;  // high partial product
    logic scl;  // scale, sign and saturate
  } mul_ctrl_t;

  typedef struct packed {
    mul_ctrl_t mul;
    coef_sel_e coef;
    opnd_sel_e opnd;
    alu_op_e   alu;
    logic      hold;  // branch to self while the output register is full
    logic      fin;   // jump back to idle
  } ucode_t;

  // control program, one word per step
  function automatic ucode_t ucode(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{mul: '0, coef: C_PI, opnd: O_E0, alu: ALU_NOP, hold: 1'b0, fin: 1'b0};
    case (pc)
      5'd0: begin
        w.mul.ld = 1'b1; w.coef = C_PI; w.opnd = O_E0; w.alu = ALU_DD;
      end
      5'd1: begin
        w.mul.mlo = 1'b1;
      end
      5'd2: begin
        w.mul.mhi = 1'b1; w.mul.ld = 1'b1; w.coef = C_P; w.opnd = O_E1;
      end
      5'd3: begin
        w.mul.scl = 1'b1; w.mul.mlo = 1'b1;
      end
      5'd4: begin
        w.alu = ALU_ACC_ADD; w.mul.mhi = 1'b1;
        w.mul.ld = 1'b1; w.coef = C_D; w.opnd = O_X;
      end
      5'd5: begin
        w.mul.scl = 1'b1; w.mul.mlo = 1'b1;
      end
      5'd6: begin
        w.alu = ALU_ACC_SUB; w.mul.mhi = 1'b1;
      end
      5'd7: begin
        w.mul.scl = 1'b1;
      end
      5'd8: begin
        w.alu = ALU_SUMD;
      end
      5'd9: begin
        w.mul.ld = 1'b1; w.coef = C_FA; w.opnd = O_X;
      end
      5'd10: begin
        w.mul.mlo = 1'b1;
      end
      5'd11: begin
        w.mul.mhi = 1'b1; w.mul.ld = 1'b1; w.coef = C_FB; w.opnd = O_FD1;
      end
      5'd12: begin
        w.mul.scl = 1'b1; w.mul.mlo = 1'b1;
      end
      5'd13: begin
        w.alu = ALU_MOVT; w.mul.mhi = 1'b1;
      end
      5'd14: begin
        w.mul.scl = 1'b1;
      end
      5'd15: begin
        w.alu = ALU_FD;
      end
      5'd16: begin
        w.alu = ALU_ACC_FD;
      end
      5'd17: begin
        w.alu = ALU_CLAMP;
      end
      5'd18: begin
        w.alu = ALU_EMIT; w.hold = 1'b1; w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/pvfd_mulq.sv */
// Shared Q16.16 multiplier: 32-bit signed coefficient times a 50-bit signed value,
// magnitude truncated by 16 bits and saturated to 48 bits, in two 32x32 passes.
// Depends on pvfd_pkg.
module pvfd_mulq (
  input  logic                    clk_i,
  input  pvfd_pkg::mul_ctrl_t     ctrl_i,
  input  logic signed [31:0]      coef_i,
  input  logic signed [49:0]      opnd_i,
  output logic signed [47:0]      prod_o
);

  localparam logic [48:0] MagMax = 49'd1 << 47;

  logic        neg_q, neg_h_q;
  logic [31:0] ua_q;
  logic [49:0] ub_q;
  logic [63:0] pl_q;
  logic [49:0] ph_q;
  logic signed [47:0] prod_q;

  logic [31:0] ua_d;
  logic [49:0] ub_d;
  logic [31:0] mb;
  logic [63:0] mp;
  logic [48:0] m;
  logic        big;
  logic [48:0] mag;
  logic [47:0] res;

  // sign and magnitude of the operands
  assign ua_d = coef_i[31] ? (~coef_i + 32'd1) : coef_i;
  assign ub_d = opnd_i[49] ? (~opnd_i + 50'd1) : opnd_i;

  // one 32x32 multiplier, low or high slice of the value
  assign mb = ctrl_i.mhi ? {14'd0, ub_q[49:32]} : ub_q[31:0];
  assign mp = ua_q * mb;

  // recombine, truncate, saturate
  assign big = |ph_q[49:31];
  assign m   = {2'b00, ph_q[30:0], 16'h0000} + {1'b0, pl_q[63:16]};

  always_comb begin
    if (neg_h_q) begin
      mag = (big || (m > MagMax)) ? MagMax : m;
      res = ~mag[47:0] + 48'd1;
    end else begin
      mag = (big || (m > (MagMax - 49'd1))) ? (MagMax - 49'd1) : m;
      res = mag[47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld) begin
      neg_q <= coef_i[31] ^ opnd_i[49];
      ua_q  <= ua_d;
      ub_q  <= ub_d;
    end
    if (ctrl_i.mlo) begin
      pl_q <= mp;
    end
    if (ctrl_i.mhi) begin
      ph_q    <= mp[49:0];
      neg_h_q <= neg_q;
    end
    if (ctrl_i.scl) begin
      prod_q <= res;
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/pid_velocity_filtered_derivative.sv */
// Velocity-form PID with first-order filtered derivative, microcoded sequencer
// over one shared multiplier. Depends on pvfd_pkg and pvfd_mulq.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[31:0] setpoint, [63:32] measured
// m_axis    out  m_axis_tvalid/tready        tdata[31:0] drive
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i register, cfg_data_i value
//
// An item runs a 19-step program: five products, each two passes through the one
// 32x32 multiplier, then serial saturating adds, the clamp and the output step.
// The next item is taken only once the sequencer is idle again, the cycle after the result is registered.
// Reset clears the sequencer and the controller history but e0_q, and sets the
// configuration registers to defaults. A stalled output keeps its register; if it
// is still full at the last step the sequencer waits there.
module pid_velocity_filtered_derivative (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] setpoint, [63:32] measured
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] drive
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pvfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // configuration
  logic signed [31:0] coef_pi_q, coef_p_q, coef_d_q, filt_a_q, filt_b_q;
  logic signed [31:0] out_min_q, out_max_q;

  // controller history
  logic signed [32:0] e0_q, e1_q, e2_q;
  logic signed [47:0] draw_q, dfilt_q, acc_q;

  // working registers
  logic signed [49:0] x_q, t_q;

  // sequencer
  logic                     busy_q;
  logic [pvfd_pkg::PcW-1:0] pc_q;
  logic                     out_valid_q;
  logic [31:0]              out_data_q;

  pvfd_pkg::ucode_t   uw;
  logic               stall;
  logic               emit;
  logic               in_acc;
  logic signed [31:0] coef_mux;
  logic signed [49:0] opnd_mux;
  logic signed [47:0] prod;
  pvfd_pkg::mul_ctrl_t mul_ctrl;

  logic signed [49:0] prod_x, acc_x, dd_x, fd_sum;
  logic signed [35:0] dd;
  logic signed [47:0] fd, lo48, hi48;
  logic [31:0]        quot;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // current control word
  always_comb begin
    uw = pvfd_pkg::ucode(pc_q);
    stall = uw.hold && out_valid_q && !m_axis_tready;
    emit = busy_q && !stall && (uw.alu == pvfd_pkg::ALU_EMIT);
    mul_ctrl = busy_q ? uw.mul : '0;
  end

  // multiplier operand selection
  always_comb begin
    case (uw.coef)
      pvfd_pkg::C_PI: coef_mux = coef_pi_q;
      pvfd_pkg::C_P:  coef_mux = coef_p_q;
      pvfd_pkg::C_D:  coef_mux = coef_d_q;
      pvfd_pkg::C_FA: coef_mux = filt_a_q;
      pvfd_pkg::C_FB: coef_mux = filt_b_q;
      default:        coef_mux = coef_pi_q;
    endcase
    case (uw.opnd)
      pvfd_pkg::O_E0:  opnd_mux = 50'(e0_q);
      pvfd_pkg::O_E1:  opnd_mux = 50'(e1_q);
      pvfd_pkg::O_X:   opnd_mux = x_q;
      pvfd_pkg::O_FD1: opnd_mux = 50'(dfilt_q);
      default:         opnd_mux = x_q;
    endcase
  end

  pvfd_mulq u_mulq (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .coef_i (coef_mux),
    .opnd_i (opnd_mux),
    .prod_o (prod)
  );

  // datapath arithmetic
  assign prod_x = 50'(prod);
  assign acc_x  = 50'(acc_q);
  assign dd     = 36'(e0_q) - (36'(e1_q) <<< 1) + 36'(e2_q);
  assign dd_x   = 50'(dd);
  assign fd     = sat48(t_q - prod_x);
  assign fd_sum = acc_x + 50'(dfilt_q);
  assign lo48   = {out_min_q, 16'h0000};
  assign hi48   = {out_max_q, 16'h0000};
  assign quot   = acc_q[47:16] + {31'd0, acc_q[47] && (|acc_q[15:0])};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_pi_q <= '0;
      coef_p_q  <= '0;
      coef_d_q  <= '0;
      filt_a_q  <= '0;
      filt_b_q  <= '0;
      out_min_q <= {1'b1, 31'd0};
      out_max_q <= {1'b0, {31{1'b1}}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pvfd_pkg::REG_COEF_PI: coef_pi_q <= cfg_data_i;
        pvfd_pkg::REG_COEF_P:  coef_p_q  <= cfg_data_i;
        pvfd_pkg::REG_COEF_D:  coef_d_q  <= cfg_data_i;
        pvfd_pkg::REG_FILT_A:  filt_a_q  <= cfg_data_i;
        pvfd_pkg::REG_FILT_B:  filt_b_q  <= cfg_data_i;
        pvfd_pkg::REG_OUT_MIN: out_min_q <= cfg_data_i;
        pvfd_pkg::REG_OUT_MAX: out_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one taken at this edge
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
      end else if (busy_q && !stall) begin
        if (uw.fin) begin
          busy_q <= 1'b0;
          pc_q   <= '0;
        end else begin
          pc_q <= pc_q + 1'b1;
        end
      end
    end
  end

  // controller history, updated by the program
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q    <= '0;
      e2_q    <= '0;
      draw_q  <= '0;
      dfilt_q <= '0;
      acc_q   <= '0;
    end else if (busy_q && !stall) begin
      case (uw.alu)
        pvfd_pkg::ALU_ACC_SUB: acc_q <= sat48(t_q - prod_x);
        pvfd_pkg::ALU_SUMD:    draw_q <= prod;
        pvfd_pkg::ALU_FD:      dfilt_q <= fd;
        pvfd_pkg::ALU_ACC_FD:  acc_q <= sat48(fd_sum);
        pvfd_pkg::ALU_CLAMP: begin
          if (acc_q < lo48) begin
            acc_q <= lo48;
          end else if (acc_q > hi48) begin
            acc_q <= hi48;
          end
          e2_q <= e1_q;
          e1_q <= e0_q;
        end
        default: ;
      endcase
    end
  end

  // working registers and result data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e0_q <= 33'($signed(s_axis_tdata[31:0])) - 33'($signed(s_axis_tdata[63:32]));
    end
    if (busy_q && !stall) begin
      case (uw.alu)
        pvfd_pkg::ALU_DD:      x_q <= dd_x;
        pvfd_pkg::ALU_ACC_ADD: t_q <= acc_x + prod_x;
        pvfd_pkg::ALU_SUMD:    x_q <= prod_x + 50'(draw_q);
        pvfd_pkg::ALU_MOVT:    t_q <= prod_x;
        pvfd_pkg::ALU_EMIT:    out_data_q <= quot;
        default: ;
      endcase
    end
  end

  // checks
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= pvfd_pkg::LastStep)
    else $error("step counter beyond program end");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && pc_q == pvfd_pkg::LastStep))
    else $error("result raised outside the output step");

  a_clamp_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pc_q == pvfd_pkg::LastStep && out_min_q <= out_max_q)
      |-> (acc_q >= lo48 && acc_q <= hi48))
    else $error("accumulator outside clamp bounds");

endmodule
